### design/move_to_front_rotating_queue_unit_macros.svh
// Assertion macros used by the move-to-front queue checker.
`ifndef MOVE_TO_FRONT_ROTATING_QUEUE_UNIT_MACROS_SVH
`define MOVE_TO_FRONT_ROTATING_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MTFQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MTFQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mtfq_pkg.sv
// Types and constants for the move-to-front rotating queue.
package mtfq_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DEF_ID_WIDTH = 32;
  localparam int IN_ID_W      = 32;
  localparam int OUT_ID_W     = 32;
  localparam int FILL_W       = 7;

  typedef enum logic [1:0] {
    KIND_SERVE    = 2'd0,
    KIND_EXPEDITE = 2'd1,
    KIND_RELOAD   = 2'd2,
    KIND_NOP      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [IN_ID_W-1:0]   citizen_id;
  } in_item_t;

  typedef struct packed {
    logic [OUT_ID_W-1:0]  served_id;
    status_t              status;
  } out_item_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic  go;
    kind_t kind;
    logic  ins_ok;
  } cell_ctrl_t;

endpackage

### design/mtfq_cell.sv
// One queue slot: holds an entry and its valid bit, trades with its neighbors.
module mtfq_cell #(
  parameter int IDX      = 0,
  parameter int ID_WIDTH = mtfq_pkg::DEF_ID_WIDTH,
  parameter int CNT_W    = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtfq_pkg::cell_ctrl_t ctrl,
  input  logic [ID_WIDTH-1:0]  id,
  input  logic [CNT_W-1:0]     fill_n,
  input  logic [ID_WIDTH-1:0]  head,
  input  logic [ID_WIDTH-1:0]  prev_entry,
  input  logic                 prev_valid,
  input  logic [ID_WIDTH-1:0]  next_entry,
  input  logic                 next_valid,
  input  logic                 seen_in,
  output logic                 seen_out,
  output logic [ID_WIDTH-1:0]  entry_out,
  output logic                 valid_out
);
  import mtfq_pkg::*;

  localparam logic [ID_WIDTH-1:0] RELOAD_VAL = ID_WIDTH'(IDX + 1);
  localparam logic [CNT_W-1:0]    IDX_C      = CNT_W'(IDX);

  logic [ID_WIDTH-1:0] entry_r, entry_nxt;
  logic                valid_r, valid_nxt;
  logic                match;

  assign match     = valid_r && (entry_r == id);
  assign seen_out  = seen_in | match;
  assign entry_out = entry_r;
  assign valid_out = valid_r;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctrl.go) begin
      unique case (ctrl.kind)
        KIND_SERVE: begin
          // pull from the rear neighbor; the last valid slot takes the head
          if (next_valid) begin
            entry_nxt = next_entry;
          end else if (valid_r) begin
            entry_nxt = head;
          end
        end
        KIND_EXPEDITE: begin
          if (ctrl.ins_ok) begin
            if (IDX == 0) begin
              entry_nxt = id;
              valid_nxt = 1'b1;
            end else if (prev_valid && !seen_in) begin
              // shift back up to and including the first match
              entry_nxt = prev_entry;
              valid_nxt = 1'b1;
            end
          end
        end
        KIND_RELOAD: begin
          valid_nxt = (IDX_C < fill_n);
          entry_nxt = valid_nxt ? RELOAD_VAL : '0;
        end
        KIND_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### design/move_to_front_rotating_queue_unit.sv
// Move-to-front rotating queue: a row of CAPACITY slot cells, position 0 at the front.
// Takes one transaction per clock unless stalled and returns its result from an output
// register the next cycle; in_stall rises only while that register holds an untaken
// result. Serve, expedite and reload all complete in the cycle of acceptance; the path
// that sets the clock is the match chain rippling from the front cell through every
// cell to decide found. Entry values need no reset: a slot is read only while valid.
module move_to_front_rotating_queue_unit #(
  parameter int CAPACITY = mtfq_pkg::DEF_CAPACITY,
  parameter int ID_WIDTH = mtfq_pkg::DEF_ID_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mtfq_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mtfq_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [mtfq_pkg::FILL_W-1:0]       cfg_wdata
);
  import mtfq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  logic [FILL_W-1:0]   fill_r;
  logic [CNT_W-1:0]    fill_n;
  logic                in_acc;
  logic [ID_WIDTH-1:0] id;
  logic                full;
  logic                found;
  cell_ctrl_t          ctrl;

  logic [ID_WIDTH-1:0] ent_w [0:CAPACITY+1];
  logic                vld_w [0:CAPACITY+1];
  logic                seen_w [0:CAPACITY];

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign id       = ID_WIDTH'(in_data.citizen_id);

  assign fill_n = (CMP_W'(fill_r) > CMP_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(fill_r);

  // pad the chain ends so every cell sees an empty neighbor there
  assign ent_w[0]          = '0;
  assign vld_w[0]          = 1'b0;
  assign ent_w[CAPACITY+1] = '0;
  assign vld_w[CAPACITY+1] = 1'b0;
  assign seen_w[0]         = 1'b0;

  assign full  = vld_w[CAPACITY];
  assign found = seen_w[CAPACITY];

  assign ctrl.go     = in_acc;
  assign ctrl.kind   = in_data.kind;
  assign ctrl.ins_ok = found | ~full;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    mtfq_cell #(
      .IDX      (g),
      .ID_WIDTH (ID_WIDTH),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .id         (id),
      .fill_n     (fill_n),
      .head       (ent_w[1]),
      .prev_entry (ent_w[g]),
      .prev_valid (vld_w[g]),
      .next_entry (ent_w[g+2]),
      .next_valid (vld_w[g+2]),
      .seen_in    (seen_w[g]),
      .seen_out   (seen_w[g+1]),
      .entry_out  (ent_w[g+1]),
      .valid_out  (vld_w[g+1])
    );
  end

  always_comb begin
    out_data_nxt           = out_data_r;
    out_valid_nxt          = out_valid_r & out_stall;
    if (in_acc) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.served_id = '0;
      out_data_nxt.status    = ST_OK;
      unique case (in_data.kind)
        KIND_SERVE: begin
          if (vld_w[1]) begin
            out_data_nxt.served_id = OUT_ID_W'(ent_w[1]);
          end else begin
            out_data_nxt.status = ST_EMPTY;
          end
        end
        KIND_EXPEDITE: begin
          if (!ctrl.ins_ok) begin
            out_data_nxt.status = ST_FULL;
          end
        end
        KIND_RELOAD, KIND_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fill_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        fill_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/mtfq_checker.sv
// Port-level checker for the move-to-front queue, with its bind.
`include "move_to_front_rotating_queue_unit_macros.svh"

module mtfq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input mtfq_pkg::out_item_t         out_data
);
  import mtfq_pkg::*;

  `MTFQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `MTFQ_ASSERT_NXT(a_acc_result, clk, rst_n, in_valid && !in_stall, out_valid, "accepted transaction gave no result")
  `MTFQ_ASSERT_IMP(a_no_idle_stall, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output register")
  `MTFQ_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && (out_data.status == ST_EMPTY), out_data.served_id == '0, "empty serve reported an id")
  `MTFQ_ASSERT_IMP(a_full_zero, clk, rst_n, out_valid && (out_data.status == ST_FULL), out_data.served_id == '0, "full expedite reported an id")

endmodule

bind move_to_front_rotating_queue_unit mtfq_checker u_mtfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/sv/tb.sv
// Self-checking testbench for the move-to-front rotating queue unit.
module tb;
  import mtfq_pkg::*;

  localparam int QUEUE_DEPTH   = DEF_CAPACITY;
  localparam int SEGMENTS      = 5;
  localparam int SEGMENT_ITEMS = 128;
  localparam int CYCLE_LIMIT   = 400000;

  class mtf_scoreboard;
    logic [OUT_ID_W-1:0] slots [QUEUE_DEPTH];
    int unsigned         live_count;
    logic [FILL_W-1:0]   fill;
    out_item_t           pending_results [$];
    int unsigned         mismatches;
    int unsigned         kinds_seen [4];
    int unsigned         status_seen [3];
    int unsigned         results_seen;

    function new();
      foreach (slots[i]) slots[i] = '0;
      live_count   = 0;
      fill         = '0;
      mismatches   = 0;
      results_seen = 0;
      foreach (kinds_seen[i]) kinds_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_fill(logic [FILL_W-1:0] value);
      fill = value;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // Entries 0..upto-1 move back one place.
    function void shift_back(int unsigned upto);
      for (int i = upto; i > 0; i--) slots[i] = slots[i-1];
    endfunction

    function out_item_t apply_item(in_item_t it);
      out_item_t           res;
      logic [OUT_ID_W-1:0] head;
      int unsigned         pos;
      int unsigned         n;
      bit                  found;
      res.served_id = '0;
      res.status    = ST_OK;
      found         = 1'b0;
      pos           = 0;
      case (it.kind)
        KIND_SERVE: begin
          if (live_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            head = slots[0];
            for (int i = 0; i + 1 < live_count; i++) slots[i] = slots[i+1];
            slots[live_count-1] = head;
            res.served_id = head;
          end
        end
        KIND_EXPEDITE: begin
          for (int i = 0; i < live_count; i++) begin
            if (!found && slots[i] == it.citizen_id) begin
              found = 1'b1;
              pos   = i;
            end
          end
          if (found) begin
            shift_back(pos);
            slots[0] = it.citizen_id;
          end else if (live_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            shift_back(live_count);
            slots[0] = it.citizen_id;
            live_count++;
          end
        end
        KIND_RELOAD: begin
          n = (fill > QUEUE_DEPTH) ? QUEUE_DEPTH : fill;
          for (int i = 0; i < QUEUE_DEPTH; i++) slots[i] = (i < n) ? OUT_ID_W'(i + 1) : '0;
          live_count = n;
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(in_item_t it);
      out_item_t res;
      res = apply_item(it);
      kinds_seen[it.kind]++;
      status_seen[res.status]++;
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result id=%0h status=%0d with nothing outstanding",
                                  got.served_id, got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.served_id !== want.served_id)
          report_mismatch($sformatf("served_id %0h, expected %0h",
                                    got.served_id, want.served_id));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [FILL_W-1:0] cfg_wdata;

  mtf_scoreboard sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   cycle_count;
  int unsigned   fill_writes;

  move_to_front_rotating_queue_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("move_to_front_rotating_queue_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Note the new transaction first so a same-edge result still pops the oldest one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  task automatic send_item(kind_t kind, logic [IN_ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.kind    <= kind;
    in_data.citizen_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_fill(logic [FILL_W-1:0] value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_fill(value);
    fill_writes++;
  endtask

  task automatic send_random(int unsigned id_span);
    int unsigned         r;
    kind_t               kind;
    logic [IN_ID_W-1:0]  id;
    r = $urandom_range(99);
    if (r < 38)      kind = KIND_SERVE;
    else if (r < 88) kind = KIND_EXPEDITE;
    else if (r < 95) kind = KIND_RELOAD;
    else             kind = KIND_NOP;
    // Mostly small identifiers so expedites hit present entries and fill the queue.
    if ($urandom_range(99) < 85) id = $urandom_range(id_span);
    else                         id = $urandom;
    send_item(kind, id);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
    logic [FILL_W-1:0] value;
    int unsigned       span;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < SEGMENTS; s++) begin
      case ($urandom_range(6))
        0:       value = '0;
        1:       value = 7'd1;
        2:       value = 7'd64;
        3:       value = '1;
        4:       value = 7'd65;
        default: value = FILL_W'($urandom_range(127));
      endcase
      write_fill(value);
      send_item(KIND_RELOAD, $urandom);
      span = ((value > QUEUE_DEPTH) ? QUEUE_DEPTH : value) + 16;
      for (int i = 0; i < SEGMENT_ITEMS; i++) send_random(span);
    end
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 7;
    recv_idle_pct = 50;
    cycle_count   = 0;
    fill_writes   = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue after reset, then inserts of the extreme identifiers.
    send_item(KIND_SERVE, 32'hFFFF_FFFF);
    write_fill('0);
    send_item(KIND_RELOAD, '0);
    send_item(KIND_SERVE, '0);
    send_item(KIND_EXPEDITE, 32'hFFFF_FFFF);
    send_item(KIND_EXPEDITE, 32'h0000_0000);
    send_item(KIND_SERVE, '0);
    send_item(KIND_EXPEDITE, 32'hFFFF_FFFF);
    send_item(KIND_SERVE, '0);
    send_item(KIND_NOP, 32'hA5A5_A5A5);
    // Oversized reload saturates and leaves the queue full.
    write_fill('1);
    send_item(KIND_RELOAD, 32'h5A5A_5A5A);
    send_item(KIND_EXPEDITE, 32'd64);
    send_item(KIND_EXPEDITE, 32'd1000);
    send_item(KIND_SERVE, '0);
    send_item(KIND_EXPEDITE, 32'h5A5A_5A5A);
    send_item(KIND_EXPEDITE, 32'd32);
    // Single-entry queue rotates onto itself.
    write_fill(7'd1);
    send_item(KIND_RELOAD, '0);
    send_item(KIND_SERVE, '0);
    send_item(KIND_SERVE, '0);
    send_item(KIND_EXPEDITE, 32'd1);
    send_item(KIND_EXPEDITE, 32'd2);
    send_item(KIND_SERVE, '0);
    send_item(KIND_NOP, '0);

    run_phase(7, 50);
    run_phase(50, 7);
    run_phase(0, 0);

    wait_quiet();
    repeat (4) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
    $display("covered %0d serve, %0d expedite, %0d reload, %0d unused-kind transactions",
             sb.kinds_seen[KIND_SERVE], sb.kinds_seen[KIND_EXPEDITE],
             sb.kinds_seen[KIND_RELOAD], sb.kinds_seen[KIND_NOP]);
    $display("%0d results checked (ok %0d, empty %0d, full %0d), %0d fill_count writes",
             sb.results_seen, sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_FULL], fill_writes);
    if (sb.mismatches == 0) begin
      $display("move_to_front_rotating_queue_unit verification clean");
    end else begin
      $display("move_to_front_rotating_queue_unit verification failed");
    end
    $finish;
  end
endmodule

### move_to_front_rotating_queue_unit.f
+incdir+design
design/mtfq_pkg.sv
design/mtfq_cell.sv
design/move_to_front_rotating_queue_unit.sv
design/mtfq_checker.sv
tb/sv/tb.sv
